// ----- sv/three_body_derivative_defines.svh -----
// ----------------------------------------------------------------------------
// three_body_derivative_defines
// Assertion macros shared by the derivative evaluator. Each macro expects
// signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef THREE_BODY_DERIVATIVE_DEFINES_SVH
`define THREE_BODY_DERIVATIVE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tbd_pkg.sv -----
// ----------------------------------------------------------------------------
// tbd_pkg
// Types and fixed constants of the three-body derivative pipeline.
// ----------------------------------------------------------------------------
package tbd_pkg;

  // Pipeline shape
  localparam int unsigned GEOM_STAGES = 3;
  localparam int unsigned SQRT_STEPS  = 32;
  localparam int unsigned QUOT_BITS   = 33;
  localparam int unsigned TERM_STAGES = QUOT_BITS + 1;
  localparam int unsigned SIDE_DEPTH  = SQRT_STEPS + TERM_STAGES;
  localparam int unsigned PIPE_DEPTH  = 1 + GEOM_STAGES + SQRT_STEPS + TERM_STAGES + 1;

  // Fixed-point constants
  localparam logic [31:0] MASS_RATIO_RESET = 32'd52398601;
  localparam logic [24:0] ONE_Q24          = 25'h100_0000;
  localparam logic [32:0] FACTOR_CAP       = 33'h1_0000_0000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } state_t;

  typedef struct packed {
    logic signed [31:0] deriv_pos_x;
    logic signed [31:0] deriv_pos_y;
    logic signed [31:0] deriv_pos_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic               overflow_flag;
  } deriv_t;

  // Offsets (sign and magnitude) and pass-through values
  typedef struct packed {
    logic [31:0]        mag_dx1;
    logic [31:0]        mag_dx2;
    logic [31:0]        mag_y;
    logic [31:0]        mag_z;
    logic               neg_dx1;
    logic               neg_dx2;
    logic               neg_y;
    logic               neg_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } side_t;

  typedef struct packed {
    logic [63:0] s1;
    logic [63:0] s2;
    logic [24:0] mu24;
    logic [24:0] one24;
    side_t       side;
  } geo_t;

  typedef struct packed {
    logic [32:0] factor;
    logic [31:0] root;
    logic        flag;
  } fac_t;

  typedef struct packed {
    logic        neg;
    logic [32:0] quot;
  } term_t;

endpackage

// ----- sv/tbd_state_if.sv -----
// ----------------------------------------------------------------------------
// tbd_state_if
// Valid/ready channel carrying one state vector per transaction.
// ----------------------------------------------------------------------------
interface tbd_state_if;
  logic            valid;
  logic            ready;
  tbd_pkg::state_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/tbd_deriv_if.sv -----
// ----------------------------------------------------------------------------
// tbd_deriv_if
// Valid/ready channel carrying one derivative vector per transaction.
// ----------------------------------------------------------------------------
interface tbd_deriv_if;
  logic            valid;
  logic            ready;
  tbd_pkg::deriv_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/tbd_geom.sv -----
// ----------------------------------------------------------------------------
// tbd_geom
// Three-stage front end: offsets to both primaries, squares, squared
// distances.
// ----------------------------------------------------------------------------
module tbd_geom (
  input  logic            clk,
  input  logic            en,
  input  tbd_pkg::state_t st_i,
  input  logic [24:0]     mu24_i,
  output tbd_pkg::geo_t   geo_o
);

  typedef struct packed {
    tbd_pkg::side_t side;
    logic [24:0]    mu24;
    logic [24:0]    one24;
  } g1_t;

  typedef struct packed {
    tbd_pkg::side_t side;
    logic [24:0]    mu24;
    logic [24:0]    one24;
    logic [63:0]    q1;
    logic [63:0]    q2;
    logic [63:0]    qy;
    logic [63:0]    qz;
  } g2_t;

  g1_t           g1_r, g1_nxt;
  g2_t           g2_r, g2_nxt;
  tbd_pkg::geo_t geo_r, geo_nxt;

  logic signed [33:0] d1, d2;
  logic [24:0]        one24;

  // Offsets from the primaries at -mu and 1-mu, split into sign and magnitude
  always_comb begin
    one24 = tbd_pkg::ONE_Q24 - mu24_i;
    d1    = 34'(st_i.pos_x) + $signed({9'b0, mu24_i});
    d2    = 34'(st_i.pos_x) - $signed({9'b0, one24});
    g1_nxt.mu24          = mu24_i;
    g1_nxt.one24         = one24;
    g1_nxt.side.neg_dx1  = d1[33];
    g1_nxt.side.neg_dx2  = d2[33];
    g1_nxt.side.neg_y    = st_i.pos_y[31];
    g1_nxt.side.neg_z    = st_i.pos_z[31];
    g1_nxt.side.mag_dx1  = d1[33] ? 32'(-d1) : 32'(d1);
    g1_nxt.side.mag_dx2  = d2[33] ? 32'(-d2) : 32'(d2);
    g1_nxt.side.mag_y    = st_i.pos_y[31] ? 32'(-st_i.pos_y) : 32'(st_i.pos_y);
    g1_nxt.side.mag_z    = st_i.pos_z[31] ? 32'(-st_i.pos_z) : 32'(st_i.pos_z);
    g1_nxt.side.pos_x    = st_i.pos_x;
    g1_nxt.side.pos_y    = st_i.pos_y;
    g1_nxt.side.vel_x    = st_i.vel_x;
    g1_nxt.side.vel_y    = st_i.vel_y;
    g1_nxt.side.vel_z    = st_i.vel_z;
  end

  // Square each magnitude
  always_comb begin
    g2_nxt.side  = g1_r.side;
    g2_nxt.mu24  = g1_r.mu24;
    g2_nxt.one24 = g1_r.one24;
    g2_nxt.q1    = {32'b0, g1_r.side.mag_dx1} * {32'b0, g1_r.side.mag_dx1};
    g2_nxt.q2    = {32'b0, g1_r.side.mag_dx2} * {32'b0, g1_r.side.mag_dx2};
    g2_nxt.qy    = {32'b0, g1_r.side.mag_y} * {32'b0, g1_r.side.mag_y};
    g2_nxt.qz    = {32'b0, g1_r.side.mag_z} * {32'b0, g1_r.side.mag_z};
  end

  // Sum to squared distances; the total stays below 2^64
  always_comb begin
    geo_nxt.side  = g2_r.side;
    geo_nxt.mu24  = g2_r.mu24;
    geo_nxt.one24 = g2_r.one24;
    geo_nxt.s1    = g2_r.q1 + g2_r.qy + g2_r.qz;
    geo_nxt.s2    = g2_r.q2 + g2_r.qy + g2_r.qz;
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      g1_r  <= g1_nxt;
      g2_r  <= g2_nxt;
      geo_r <= geo_nxt;
    end
  end

  assign geo_o = geo_r;

endmodule

// ----- sv/tbd_factor.sv -----
// ----------------------------------------------------------------------------
// tbd_factor
// Per-primary unit: integer square root of the squared distance and the
// gravity factor m * 2^48 / s, one digit of each per stage.
// ----------------------------------------------------------------------------
module tbd_factor (
  input  logic          clk,
  input  logic          en,
  input  logic [63:0]   s_i,
  input  logic [24:0]   m_i,
  output tbd_pkg::fac_t fac_o
);

  localparam int unsigned STEPS = tbd_pkg::SQRT_STEPS;

  typedef struct packed {
    logic [63:0] s;
    logic        zero;
    logic        ovf;
    logic [33:0] sq_rem;
    logic [31:0] root;
    logic [63:0] dv_rem;
    logic [31:0] quot;
  } fac_stage_t;

  fac_stage_t entry;
  fac_stage_t stg_r [STEPS];

  // Seed both recurrences; the quotient saturates when m * 2^16 >= s
  always_comb begin
    entry.s      = s_i;
    entry.zero   = (s_i == 64'd0);
    entry.ovf    = ({23'b0, m_i, 16'b0} >= s_i);
    entry.sq_rem = '0;
    entry.root   = '0;
    entry.dv_rem = {23'b0, m_i, 16'b0};
    entry.quot   = '0;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    fac_stage_t  prv, nxt;
    logic [35:0] rem4, trial;
    logic [64:0] rem2;
    logic        sq_ge, dv_ge;

    if (k == 0) begin : g_first
      assign prv = entry;
    end else begin : g_rest
      assign prv = stg_r[k-1];
    end

    // One root digit and one quotient bit
    always_comb begin
      rem4  = {prv.sq_rem, prv.s[63-2*k -: 2]};
      trial = {2'b00, prv.root, 2'b01};
      sq_ge = (rem4 >= trial);
      rem2  = {prv.dv_rem, 1'b0};
      dv_ge = (rem2 >= {1'b0, prv.s});
      nxt        = prv;
      nxt.sq_rem = sq_ge ? 34'(rem4 - trial) : rem4[33:0];
      nxt.root   = {prv.root[30:0], sq_ge};
      nxt.dv_rem = dv_ge ? 64'(rem2 - {1'b0, prv.s}) : rem2[63:0];
      nxt.quot   = {prv.quot[30:0], dv_ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k] <= nxt;
      end
    end
  end

  // Zero distance drops the terms; a saturated factor is clamped
  always_comb begin
    if (stg_r[STEPS-1].zero) begin
      fac_o.factor = '0;
      fac_o.root   = 32'd1;
    end else begin
      fac_o.factor = stg_r[STEPS-1].ovf ? tbd_pkg::FACTOR_CAP
                                        : {1'b0, stg_r[STEPS-1].quot};
      fac_o.root   = stg_r[STEPS-1].root;
    end
    fac_o.flag = stg_r[STEPS-1].zero | stg_r[STEPS-1].ovf;
  end

endmodule

// ----- sv/tbd_term.sv -----
// ----------------------------------------------------------------------------
// tbd_term
// One gravity term: factor * |offset| / root, a multiply stage followed by
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module tbd_term (
  input  logic           clk,
  input  logic           en,
  input  logic [32:0]    factor_i,
  input  logic [31:0]    mag_i,
  input  logic           neg_i,
  input  logic [31:0]    den_i,
  output tbd_pkg::term_t term_o
);

  localparam int unsigned QB = tbd_pkg::QUOT_BITS;

  typedef struct packed {
    logic [63:0] prod;
    logic [31:0] den;
    logic        neg;
    logic [31:0] rem;
    logic [32:0] quot;
  } term_stage_t;

  term_stage_t mul_r, mul_nxt;
  term_stage_t dv_r [QB];
  logic [64:0] full;

  // Product stays below 2^64 since |offset| <= root and factor <= 2^32
  always_comb begin
    full         = factor_i * mag_i;
    mul_nxt.prod = full[63:0];
    mul_nxt.den  = den_i;
    mul_nxt.neg  = neg_i;
    mul_nxt.rem  = '0;
    mul_nxt.quot = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_r <= mul_nxt;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    term_stage_t prv, nxt;
    logic [32:0] rem2;
    logic        ge;

    // Quotient fits in QB bits, so the top bits form the first remainder
    if (j == 0) begin : g_first
      always_comb begin
        prv     = mul_r;
        prv.rem = {1'b0, mul_r.prod[63:QB]};
      end
    end else begin : g_rest
      assign prv = dv_r[j-1];
    end

    always_comb begin
      rem2     = {prv.rem, prv.prod[QB-1-j]};
      ge       = (rem2 >= {1'b0, prv.den});
      nxt      = prv;
      nxt.rem  = ge ? 32'(rem2 - {1'b0, prv.den}) : rem2[31:0];
      nxt.quot = {prv.quot[QB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j] <= nxt;
      end
    end
  end

  assign term_o.neg  = dv_r[QB-1].neg;
  assign term_o.quot = dv_r[QB-1].quot;

endmodule

// ----- sv/three_body_derivative.sv -----
// Depth: 71 register stages, from the input state register to the output register.
// Throughput: one state per cycle unless the output stalls; the 32-step root/factor units and the
// 33-step term dividers are fully pipelined, one digit per stage.
// A stall at the output holds the whole pipeline; the input stage still fills a bubble.
// Reset clears all valid bits and loads the default mass ratio.
// ----------------------------------------------------------------------------
// three_body_derivative
// Rotating-frame equations of motion of the restricted three-body problem,
// evaluated in fixed point with saturated acceleration outputs.
// ----------------------------------------------------------------------------
`include "three_body_derivative_defines.svh"

module three_body_derivative (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  tbd_state_if.sink   in_st,
  tbd_deriv_if.source out_dv
);

  localparam int unsigned DEPTH = tbd_pkg::PIPE_DEPTH;
  localparam int unsigned SDEP  = tbd_pkg::SIDE_DEPTH;
  localparam int unsigned TDEP  = tbd_pkg::TERM_STAGES;
  localparam int unsigned FTAP  = tbd_pkg::SQRT_STEPS - 1;
  localparam logic signed [37:0] SAT_MAX = 38'sd2147483647;
  localparam logic signed [37:0] SAT_MIN = -38'sd2147483648;

  logic [31:0]     mass_ratio_r;
  logic [DEPTH-1:0] vld_r;
  logic            en, load0;
  tbd_pkg::state_t st_r;
  logic [24:0]     mu24_r, mu24_nxt;
  tbd_pkg::geo_t   geo;
  tbd_pkg::fac_t   fac1, fac2;
  tbd_pkg::side_t  sb_r [SDEP];
  logic [TDEP-1:0] fl_r;
  tbd_pkg::side_t  tap, sd;
  tbd_pkg::term_t  tx1, ty1, tz1, tx2, ty2, tz2;
  logic signed [37:0] ax, ay, az;
  logic [32:0]     sx, sy, sz;
  tbd_pkg::deriv_t out_r, out_nxt;

  function automatic logic signed [37:0] apply_sign(input tbd_pkg::term_t t);
    logic signed [37:0] m;
    m = $signed({5'b0, t.quot});
    return t.neg ? -m : m;
  endfunction

  function automatic logic [32:0] sat32(input logic signed [37:0] v);
    logic [32:0] r;
    if (v > SAT_MAX) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < SAT_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Mass ratio register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_ratio_r <= tbd_pkg::MASS_RATIO_RESET;
    end else if (cfg_wr_en) begin
      mass_ratio_r <= cfg_wr_data;
    end
  end

  // Advance on a free or draining output; the input stage also fills when empty
  assign en          = !vld_r[DEPTH-1] || out_dv.ready;
  assign load0       = en || !vld_r[0];
  assign in_st.ready = load0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (load0) begin
        vld_r[0] <= in_st.valid;
      end
      if (en) begin
        vld_r[DEPTH-1:1] <= vld_r[DEPTH-2:0];
      end
    end
  end

  // Round mu to Q0.24 at the input stage
  assign mu24_nxt = 25'(({1'b0, mass_ratio_r} + 33'd128) >> 8);

  always_ff @(posedge clk) begin
    if (load0) begin
      st_r   <= in_st.data;
      mu24_r <= mu24_nxt;
    end
  end

  tbd_geom u_geom (
    .clk    (clk),
    .en     (en),
    .st_i   (st_r),
    .mu24_i (mu24_r),
    .geo_o  (geo)
  );

  tbd_factor u_fac1 (.clk(clk), .en(en), .s_i(geo.s1), .m_i(geo.one24), .fac_o(fac1));
  tbd_factor u_fac2 (.clk(clk), .en(en), .s_i(geo.s2), .m_i(geo.mu24), .fac_o(fac2));

  // Carry offsets and pass-through values alongside the arithmetic
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= geo.side;
      for (int k = 1; k < SDEP; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
      fl_r <= {fl_r[TDEP-2:0], fac1.flag | fac2.flag};
    end
  end

  assign tap = sb_r[FTAP];
  assign sd  = sb_r[SDEP-1];

  tbd_term u_tx1 (.clk(clk), .en(en), .factor_i(fac1.factor), .mag_i(tap.mag_dx1),
                  .neg_i(tap.neg_dx1), .den_i(fac1.root), .term_o(tx1));
  tbd_term u_ty1 (.clk(clk), .en(en), .factor_i(fac1.factor), .mag_i(tap.mag_y),
                  .neg_i(tap.neg_y), .den_i(fac1.root), .term_o(ty1));
  tbd_term u_tz1 (.clk(clk), .en(en), .factor_i(fac1.factor), .mag_i(tap.mag_z),
                  .neg_i(tap.neg_z), .den_i(fac1.root), .term_o(tz1));
  tbd_term u_tx2 (.clk(clk), .en(en), .factor_i(fac2.factor), .mag_i(tap.mag_dx2),
                  .neg_i(tap.neg_dx2), .den_i(fac2.root), .term_o(tx2));
  tbd_term u_ty2 (.clk(clk), .en(en), .factor_i(fac2.factor), .mag_i(tap.mag_y),
                  .neg_i(tap.neg_y), .den_i(fac2.root), .term_o(ty2));
  tbd_term u_tz2 (.clk(clk), .en(en), .factor_i(fac2.factor), .mag_i(tap.mag_z),
                  .neg_i(tap.neg_z), .den_i(fac2.root), .term_o(tz2));

  // Gravity, Coriolis (gain two) and centrifugal (gain one) sums, then saturate
  always_comb begin
    ax = (38'(sd.vel_y) <<< 1) + 38'(sd.pos_x) - apply_sign(tx1) - apply_sign(tx2);
    ay = 38'(sd.pos_y) - (38'(sd.vel_x) <<< 1) - apply_sign(ty1) - apply_sign(ty2);
    az = -apply_sign(tz1) - apply_sign(tz2);
    sx = sat32(ax);
    sy = sat32(ay);
    sz = sat32(az);
    out_nxt.deriv_pos_x   = sd.vel_x;
    out_nxt.deriv_pos_y   = sd.vel_y;
    out_nxt.deriv_pos_z   = sd.vel_z;
    out_nxt.accel_x       = $signed(sx[31:0]);
    out_nxt.accel_y       = $signed(sy[31:0]);
    out_nxt.accel_z       = $signed(sz[31:0]);
    out_nxt.overflow_flag = fl_r[TDEP-1] | sx[32] | sy[32] | sz[32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_dv.valid = vld_r[DEPTH-1];
  assign out_dv.data  = out_r;

  // Checks
  `TBD_ASSERT_IMP(a_ready_when_free, !out_dv.valid || out_dv.ready, in_st.ready, "input stalled while output free")
  `TBD_ASSERT_NXT(a_cfg_write, cfg_wr_en, mass_ratio_r == $past(cfg_wr_data), "mass ratio write lost")
  `TBD_ASSERT_NXT(a_last_advance, en && vld_r[DEPTH-2], out_dv.valid, "result dropped before output")

endmodule

// ----- tb/sv/tb_three_body_derivative.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_body_derivative
// Self-checking bench for the three-body derivative pipeline. State vectors
// are pushed through the valid/ready input channel under several
// mass-ratio settings and idle patterns. A scoreboard computes each
// expected derivative in exact fixed point and compares the output
// channel field by field.
// ----------------------------------------------------------------------------
module tb_three_body_derivative;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          RANDOM_ITEMS = 82;
  localparam int          NUM_PHASES   = 6;
  localparam logic [31:0] MU_HALF      = 32'h8000_0000;
  localparam logic [31:0] MU_MAX       = 32'hFFFF_FFFF;

  // --------------------------------------------------------------------------
  // Derivative predictor and store of expected derivatives
  // --------------------------------------------------------------------------
  class deriv_scoreboard;
    logic [31:0]     mass_ratio;
    tbd_pkg::deriv_t expected_q[$];
    int              mismatches;
    int              checked;

    function new();
      mass_ratio = tbd_pkg::MASS_RATIO_RESET;
      mismatches = 0;
      checked    = 0;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(0) - v : v;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // floor(num * 2^48 / den), clamped to 2^32
    function longint unsigned gravity_factor(longint unsigned num, longint unsigned den,
                                             inout bit flag);
      longint unsigned q, rem, cap;
      cap = tbd_pkg::FACTOR_CAP;
      q   = num / den;
      rem = num % den;
      if (q >= cap) begin
        flag = 1'b1;
        return cap;
      end
      for (int i = 0; i < 48; i++) begin
        q <<= 1;
        if (rem >= den - rem) begin
          rem = rem - (den - rem);
          q   = q | 1;
        end else begin
          rem <<= 1;
        end
        if (q >= cap) begin
          flag = 1'b1;
          return cap;
        end
      end
      return q;
    endfunction

    function longint pull(longint d, longint unsigned fac, longint unsigned rt);
      longint unsigned m;
      m = fac * mag(d) / rt;
      return d < 0 ? -longint'(m) : longint'(m);
    endfunction

    function longint clip32(longint v, inout bit flag);
      if (v > 64'sd2147483647) begin
        flag = 1'b1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        flag = 1'b1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function tbd_pkg::deriv_t predict(tbd_pkg::state_t s);
      longint          px, py, pz, d1, d2, gx, gy, gz;
      longint unsigned mu24, one24, yz, s1, s2, rt, fac;
      bit              flag;
      tbd_pkg::deriv_t r;
      px    = s.pos_x;
      py    = s.pos_y;
      pz    = s.pos_z;
      mu24  = ({32'd0, mass_ratio} + 128) >> 8;
      one24 = (64'd1 << 24) - mu24;
      d1    = px + longint'(mu24);
      d2    = px - longint'(one24);
      yz    = mag(py) * mag(py) + mag(pz) * mag(pz);
      s1    = mag(d1) * mag(d1) + yz;
      s2    = mag(d2) * mag(d2) + yz;
      flag  = 1'b0;
      gx    = 0;
      gy    = 0;
      gz    = 0;
      // primary: zero distance drops its terms
      if (s1 == 0) begin
        flag = 1'b1;
      end else begin
        rt  = root_floor(s1);
        fac = gravity_factor(one24, s1, flag);
        gx += pull(d1, fac, rt);
        gy += pull(py, fac, rt);
        gz += pull(pz, fac, rt);
      end
      // secondary
      if (s2 == 0) begin
        flag = 1'b1;
      end else begin
        rt  = root_floor(s2);
        fac = gravity_factor(mu24, s2, flag);
        gx += pull(d2, fac, rt);
        gy += pull(py, fac, rt);
        gz += pull(pz, fac, rt);
      end
      r.deriv_pos_x   = s.vel_x;
      r.deriv_pos_y   = s.vel_y;
      r.deriv_pos_z   = s.vel_z;
      r.accel_x       = 32'(clip32(-gx + 2 * longint'(s.vel_y) + px, flag));
      r.accel_y       = 32'(clip32(-gy - 2 * longint'(s.vel_x) + py, flag));
      r.accel_z       = 32'(clip32(-gz, flag));
      r.overflow_flag = flag;
      return r;
    endfunction

    function void note_state(tbd_pkg::state_t s);
      expected_q.insert(expected_q.size(), predict(s));
    endfunction

    function void check_deriv(tbd_pkg::deriv_t got);
      tbd_pkg::deriv_t e;
      if (expected_q.size() == 0) begin
        $error("derivative transaction with none expected");
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.deriv_pos_x !== e.deriv_pos_x) begin
        $error("deriv_pos_x expected %0d got %0d", e.deriv_pos_x, got.deriv_pos_x);
        mismatches++;
      end
      if (got.deriv_pos_y !== e.deriv_pos_y) begin
        $error("deriv_pos_y expected %0d got %0d", e.deriv_pos_y, got.deriv_pos_y);
        mismatches++;
      end
      if (got.deriv_pos_z !== e.deriv_pos_z) begin
        $error("deriv_pos_z expected %0d got %0d", e.deriv_pos_z, got.deriv_pos_z);
        mismatches++;
      end
      if (got.accel_x !== e.accel_x) begin
        $error("accel_x expected %0d got %0d", e.accel_x, got.accel_x);
        mismatches++;
      end
      if (got.accel_y !== e.accel_y) begin
        $error("accel_y expected %0d got %0d", e.accel_y, got.accel_y);
        mismatches++;
      end
      if (got.accel_z !== e.accel_z) begin
        $error("accel_z expected %0d got %0d", e.accel_z, got.accel_z);
        mismatches++;
      end
      if (got.overflow_flag !== e.overflow_flag) begin
        $error("overflow_flag expected %0b got %0b", e.overflow_flag, got.overflow_flag);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  int          cycles = 0;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          sent;

  tbd_state_if in_st();
  tbd_deriv_if out_dv();

  deriv_scoreboard sb = new();

  three_body_derivative uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_st      (in_st),
    .out_dv     (out_dv)
  );

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check derivative transactions and stall the output at random
  always @(posedge clk) begin
    if (rst_n && out_dv.valid && out_dv.ready) sb.check_deriv(out_dv.data);
    out_dv.ready <= rst_n && ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Hold the state until the transaction completes, idling first at random
  task automatic send_state(tbd_pkg::state_t s);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_st.valid <= 1'b0;
      @(posedge clk);
    end
    in_st.valid <= 1'b1;
    in_st.data  <= s;
    do @(posedge clk); while (!in_st.ready);
    sb.note_state(s);
    sent++;
  endtask

  // Drain the pipeline, then load a new mass ratio
  task automatic write_mass_ratio(logic [31:0] v);
    in_st.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.mass_ratio = v;
  endtask

  function automatic int jitter();
    int k, m;
    k = $urandom_range(0, 24);
    m = $urandom_range(0, 1 << k);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic int mu_q24();
    return int'(({32'd0, sb.mass_ratio} + 128) >> 8);
  endfunction

  function automatic tbd_pkg::state_t make_state(int px, int py, int pz,
                                                 int vx, int vy, int vz);
    tbd_pkg::state_t s;
    s.pos_x = px;
    s.pos_y = py;
    s.pos_z = pz;
    s.vel_x = vx;
    s.vel_y = vy;
    s.vel_z = vz;
    return s;
  endfunction

  // Mostly orbit-scale states and states close to a primary, some full-range noise
  function automatic tbd_pkg::state_t random_state();
    tbd_pkg::state_t s;
    int              pick;
    pick = $urandom_range(0, 9);
    s = make_state($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (pick < 4) begin
      s.pos_x = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      s.pos_y = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      s.pos_z = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      s.vel_x = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      s.vel_y = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
    end else if (pick < 8) begin
      s.pos_x = ($urandom_range(0, 1) ? (1 << 24) - mu_q24() : -mu_q24()) + jitter();
      s.pos_y = $urandom_range(0, 2) == 0 ? 0 : jitter();
      s.pos_z = $urandom_range(0, 2) == 0 ? 0 : jitter();
    end
    return s;
  endfunction

  task automatic run_directed();
    int mu;
    mu = mu_q24();
    send_state(make_state(0, 0, 0, 0, 0, 0));
    send_state(make_state(-mu, 0, 0, 1, 2, 3));
    send_state(make_state((1 << 24) - mu, 0, 0, -1, -2, -3));
    send_state(make_state(-mu + 1, 0, 0, 0, 0, 0));
    send_state(make_state((1 << 24) - mu, 1, 0, 0, 0, 0));
    send_state(make_state(-mu, 0, -1, 0, 0, 0));
    send_state(make_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_state(make_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_state(make_state(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_state(make_state(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    send_state(make_state(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    send_state(make_state(32'h0080_0000, 32'h0100_0000, 32'h0040_0000,
                          32'h0020_0000, -32'sh0020_0000, 32'h0001_0000));
    send_state(make_state(-1, -1, -1, -1, -1, -1));
    send_state(make_state(1, 1, 1, 1, 1, 1));
    send_state(make_state(-mu, 0, 1, 0, 0, 0));
  endtask

  // Stimulus
  initial begin
    logic [31:0] ratios[NUM_PHASES];
    ratios[0] = tbd_pkg::MASS_RATIO_RESET;
    ratios[1] = 32'd0;
    ratios[2] = MU_HALF;
    ratios[3] = MU_MAX;
    ratios[4] = $urandom_range(0, MU_HALF);
    ratios[5] = tbd_pkg::MASS_RATIO_RESET;
    sent               = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_st.valid        = 1'b0;
    in_st.data         = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) write_mass_ratio(ratios[p]);
      // rotate through the idle patterns
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
        default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
      endcase
      if (p < 4) run_directed();
      for (int i = 0; i < RANDOM_ITEMS; i++) send_state(random_state());
    end
    in_st.valid <= 1'b0;

    // Let the pipeline empty
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d state vectors over %0d mass-ratio settings and idle patterns;",
             sent, NUM_PHASES);
    $display("compared %0d derivatives, %0d field errors.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
